/* rtl/core/round_robin_task_slot_manager_core_defines.svh */
// Assertion macros for the task slot manager checker.
`ifndef ROUND_ROBIN_TASK_SLOT_MANAGER_CORE_DEFINES_SVH
`define ROUND_ROBIN_TASK_SLOT_MANAGER_CORE_DEFINES_SVH

// same-cycle implication
`define RRTS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrts assertion failed");

// next-cycle implication
`define RRTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrts assertion failed");

`endif

/* rtl/core/rrts_pkg.sv */
// Package: sizes, request codes, payload types and helpers of the task slot manager.
package rrts_pkg;

  localparam int SLOTS        = 4;
  localparam int PAGE_BYTES   = 4096;
  localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W        = $clog2(SLOTS + 1);
  localparam int SLOT_FIELD_W = 6;

  localparam logic [2:0] FUNC_SCHED   = 3'd0;
  localparam logic [2:0] FUNC_KCREATE = 3'd1;
  localparam logic [2:0] FUNC_UCREATE = 3'd2;
  localparam logic [2:0] FUNC_DESTROY = 3'd3;
  localparam logic [2:0] FUNC_FINISH  = 3'd4;

  typedef logic [SLOT_W-1:0]       slot_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [SLOT_FIELD_W-1:0] slot_field_t;
  typedef logic [SLOT_FIELD_W:0]   slot_ext_t;
  typedef logic [15:0]             size_t;

  typedef struct packed {
    logic [2:0]  func;
    slot_field_t target_slot;
    logic        entry_present;
    logic        image_present;
    size_t       image_size;
    size_t       start_offset;
    logic        space_ok;
    logic        free_ok;
  } in_t;

  typedef struct packed {
    logic        ok;
    slot_field_t created_slot;
    slot_field_t next_task;
    logic        save_context;
    logic        next_is_user;
  } out_t;

  // round-robin successor
  function automatic slot_t slot_inc(input slot_t s);
    return (s == slot_t'(SLOTS - 1)) ? '0 : s + slot_t'(1);
  endfunction

endpackage

/* rtl/core/round_robin_task_slot_manager_core.sv */
// Task slot manager: runnable/user-space bits per slot, current slot, request sequencer.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one request item (func and its
//   arguments); output channel out_valid/out_stall/out_data returns one result item
//   per request. cfg_we/cfg_wdata writes the enabled bit; the user must write it
//   only while idle, which the block itself does not enforce.
// Sequencing:
//   Destroy, finish, unused codes and requests that fail their first check
//   (scheduler disabled, bad create arguments) go from PROBE to TAIL; schedule and
//   create also pass through SCAN, which reads one slot bit per cycle through a
//   single shared index and compare. out_valid rises as TAIL loads the output
//   register. One request is in flight at a time: in_stall is high from the accept
//   until that load, and the next item is taken the cycle after it at the earliest.
// Reset:
//   Slot 0 runnable, all other bits clear, current slot 0, enabled set, no
//   result pending.
// Receiver stall:
//   A result held in the output register stays unchanged. A new request is still
//   taken, but its result waits in the sequencer until the register frees.
module round_robin_task_slot_manager_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  rrts_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rrts_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic           cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PROBE = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_TAIL  = 4'b1000
  } state_t;

  state_t                    state;
  rrts_pkg::in_t             req;
  rrts_pkg::slot_t           idx;
  rrts_pkg::slot_t           cur;
  rrts_pkg::cnt_t            cnt;
  logic [rrts_pkg::SLOTS-1:0] runnable;
  logic [rrts_pkg::SLOTS-1:0] user_space;
  logic                      enabled;
  logic                      r_ok;
  logic                      r_save;
  rrts_pkg::slot_field_t     r_created;

  logic idx_runnable;
  logic idx_user;
  logic image_ok;
  logic create_ok;
  logic target_ok;
  logic last_step;
  logic out_free;

  assign in_stall     = (state != ST_IDLE);
  assign idx_runnable = runnable[idx];
  assign idx_user     = user_space[idx];
  assign last_step    = (cnt == rrts_pkg::cnt_t'(1));
  assign out_free     = !out_valid || !out_stall;

  assign image_ok = req.image_present && (req.image_size != '0) &&
                    (req.image_size <= rrts_pkg::size_t'(rrts_pkg::PAGE_BYTES)) &&
                    (req.start_offset < req.image_size);
  assign create_ok = enabled &&
                     ((req.func == rrts_pkg::FUNC_KCREATE) ? req.entry_present : image_ok);
  assign target_ok = (req.target_slot != '0) &&
                     (rrts_pkg::slot_ext_t'(req.target_slot) <
                      rrts_pkg::slot_ext_t'(rrts_pkg::SLOTS)) &&
                     (req.target_slot != rrts_pkg::slot_field_t'(cur));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cur        <= '0;
      runnable   <= {{(rrts_pkg::SLOTS-1){1'b0}}, 1'b1};
      user_space <= '0;
      enabled    <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        enabled <= cfg_wdata;
      end
      if (state == ST_TAIL && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req       <= in_data;
            r_ok      <= 1'b0;
            r_save    <= 1'b0;
            r_created <= '0;
            state     <= ST_PROBE;
            if (in_data.func == rrts_pkg::FUNC_DESTROY) begin
              idx <= in_data.target_slot[rrts_pkg::SLOT_W-1:0];
              cnt <= rrts_pkg::cnt_t'(rrts_pkg::SLOTS);
            end else if (in_data.func == rrts_pkg::FUNC_KCREATE ||
                         in_data.func == rrts_pkg::FUNC_UCREATE) begin
              idx <= rrts_pkg::slot_t'(1);
              cnt <= rrts_pkg::cnt_t'(rrts_pkg::SLOTS - 1);
            end else begin
              idx <= cur;
              cnt <= rrts_pkg::cnt_t'(rrts_pkg::SLOTS);
            end
          end
        end
        ST_PROBE: begin
          unique case (req.func)
            rrts_pkg::FUNC_SCHED: begin
              if (enabled) begin
                r_save <= idx_runnable;
                idx    <= rrts_pkg::slot_inc(idx);
                state  <= ST_SCAN;
              end else begin
                state <= ST_TAIL;
              end
            end
            rrts_pkg::FUNC_KCREATE, rrts_pkg::FUNC_UCREATE: begin
              if (create_ok) begin
                state <= ST_SCAN;
              end else begin
                idx   <= cur;
                state <= ST_TAIL;
              end
            end
            rrts_pkg::FUNC_DESTROY: begin
              if (enabled && target_ok && idx_runnable && (!idx_user || req.free_ok)) begin
                runnable[idx]   <= 1'b0;
                user_space[idx] <= 1'b0;
                r_ok            <= 1'b1;
              end
              idx   <= cur;
              state <= ST_TAIL;
            end
            rrts_pkg::FUNC_FINISH: begin
              runnable[idx] <= 1'b0;
              r_ok          <= 1'b1;
              state         <= ST_TAIL;
            end
            default: begin
              state <= ST_TAIL;
            end
          endcase
        end
        ST_SCAN: begin
          cnt <= cnt - rrts_pkg::cnt_t'(1);
          if (req.func == rrts_pkg::FUNC_SCHED) begin
            if (idx_runnable) begin
              cur   <= idx;
              r_ok  <= 1'b1;
              state <= ST_TAIL;
            end else if (last_step) begin
              r_ok  <= 1'b1;
              idx   <= cur;
              state <= ST_TAIL;
            end else begin
              idx <= rrts_pkg::slot_inc(idx);
            end
          end else begin
            if (!idx_runnable) begin
              if (req.func == rrts_pkg::FUNC_KCREATE || req.space_ok) begin
                runnable[idx]   <= 1'b1;
                user_space[idx] <= (req.func == rrts_pkg::FUNC_UCREATE);
                r_created       <= rrts_pkg::slot_field_t'(idx);
                r_ok            <= 1'b1;
              end
              idx   <= cur;
              state <= ST_TAIL;
            end else if (last_step) begin
              idx   <= cur;
              state <= ST_TAIL;
            end else begin
              idx <= rrts_pkg::slot_inc(idx);
            end
          end
        end
        ST_TAIL: begin
          if (out_free) begin
            out_data.ok           <= r_ok;
            out_data.created_slot <= r_created;
            out_data.next_task    <= rrts_pkg::slot_field_t'(cur);
            out_data.save_context <= r_save;
            out_data.next_is_user <= idx_user;
            state                 <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/rrts_checker.sv */
// Port-level checker for the task slot manager, bound to the top level.
`include "round_robin_task_slot_manager_core_defines.svh"

module rrts_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input rrts_pkg::out_t out_data
);

  `RRTS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `RRTS_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(out_data))
  `RRTS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `RRTS_ASSERT_NOW(a_fail_no_slot, clk, rst, out_valid && !out_data.ok, out_data.created_slot == '0)

endmodule

bind round_robin_task_slot_manager_core rrts_checker u_rrts_checker (.*);
